// ----- rtl/hbd_pkg.sv -----
package hbd_pkg;

    localparam int MAX_SIZE_LINE_DEF = 1000;
    localparam int LENGTH_BITS_DEF   = 32;
    localparam int LINE_LEN_W        = 10;
    localparam int CFG_DATA_W        = 32;
    localparam int CFG_INDEX_W       = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_CHUNKED_MODE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONTENT_LENGTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COMBINE_CHUNKS = 2'd2;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_BYTE  = 1'b1;

    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_SIZE  = 3'd1,
        PH_DATA  = 3'd2,
        PH_TERM  = 3'd3,
        PH_FIXED = 3'd4,
        PH_DONE  = 3'd5,
        PH_ERROR = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        ST_MORE  = 2'd0,
        ST_CHUNK = 2'd1,
        ST_BODY  = 2'd2,
        ST_ERR   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_BAD_SIZE = 3'd1,
        ERR_OVERFLOW = 3'd2,
        ERR_LONG     = 3'd3,
        ERR_BAD_TERM = 3'd4
    } err_t;

    // hex digit check and value
    function automatic logic is_hex(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
               (b >= 8'h41 && b <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [3:0] v;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = b[3:0];
        end else begin
            v = 4'(b[3:0] + 4'd9);  // 'a'/'A' have low nibble 1
        end
        return v;
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0B || b == 8'h0C;
    endfunction

endpackage

// ----- rtl/http_body_dechunker.sv -----
// HTTP body extractor, one stream byte per item.
// Input channel (s_valid/s_ready): s_req_type 0 starts a message and picks
// the mode from the configuration registers; s_req_type 1 carries
// s_data_byte. Fixed mode passes content_length bytes; chunked mode parses
// hex size lines, passes chunk data and checks the CRLF after each chunk.
// Result channel (m_valid/m_ready): exactly one result per input item with
// body byte (if any), consumed flag, status and error kind.
// Configuration: cfg_wr_en/cfg_index/cfg_data; the user must write it only
// while idle, which the block does not enforce. One output register holds each
// result, which appears in the cycle after its item is accepted. One item per
// cycle while m_ready is high; the parser update is one shift/add/compare step.
// When the receiver stalls, the output register holds its result and
// s_ready drops until it is taken; nothing is lost.
// Reset (aresetn low, synchronous): parser returns to idle, output empty,
// chunked_mode 0, content_length 0, combine_chunks 1.
// After body complete or error, bytes are not consumed until the next start.
module http_body_dechunker
    import hbd_pkg::*;
#(
    parameter int MAX_SIZE_LINE = MAX_SIZE_LINE_DEF,
    parameter int LENGTH_BITS   = LENGTH_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_req_type,
    input  logic [7:0]             s_data_byte,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_body_valid,
    output logic [7:0]             m_body_byte,
    output logic                   m_consumed,
    output logic [1:0]             m_status,
    output logic [2:0]             m_error_kind
);

    localparam int LW = LENGTH_BITS;

    // configuration
    logic                  chunked_mode_reg;
    logic [CFG_DATA_W-1:0] content_length_reg;
    logic                  combine_chunks_reg;

    // parser state
    phase_t                phase_reg, phase_next;
    logic [LW-1:0]         bytes_left_reg, bytes_left_next;
    logic [LW-1:0]         size_accum_reg, size_accum_next;
    logic                  digit_seen_reg, digit_seen_next;
    logic                  digits_ended_reg, digits_ended_next;
    logic                  size_overflow_reg, size_overflow_next;
    logic [LINE_LEN_W-1:0] line_length_reg, line_length_next;
    logic                  term_first_ok_reg, term_first_ok_next;
    logic                  term_count_reg, term_count_next;
    err_t                  error_code_reg, error_code_next;

    // result register
    logic       m_valid_reg;
    logic       body_valid_reg, body_valid_next;
    logic [7:0] body_byte_reg, body_byte_next;
    logic       consumed_reg, consumed_next;
    status_t    status_reg, status_next;
    err_t       error_kind_reg, error_kind_next;

    logic          s_accept;
    logic [63:0]   cl_wide;
    logic [LW-1:0] cl_len;
    phase_t        start_phase;
    phase_t        eff_phase;
    logic [LW-1:0] eff_bytes_left;
    logic          line_full;
    logic          accum_top_set;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    assign cl_wide = {{(64 - CFG_DATA_W){1'b0}}, content_length_reg};
    assign cl_len  = cl_wide[LW-1:0];

    assign start_phase = chunked_mode_reg ? PH_SIZE :
                         (cl_len == '0) ? PH_DONE : PH_FIXED;

    // a byte that arrives before any start behaves as if a start came first
    assign eff_phase      = (phase_reg == PH_IDLE) ? start_phase : phase_reg;
    assign eff_bytes_left = (phase_reg == PH_IDLE && !chunked_mode_reg) ?
                            cl_len : bytes_left_reg;

    assign line_full     = line_length_reg >= LINE_LEN_W'(MAX_SIZE_LINE);
    assign accum_top_set = size_accum_reg[LW-1 -: 4] != 4'd0;

    // next parser state
    always_comb begin
        phase_next         = phase_reg;
        bytes_left_next    = bytes_left_reg;
        size_accum_next    = size_accum_reg;
        digit_seen_next    = digit_seen_reg;
        digits_ended_next  = digits_ended_reg;
        size_overflow_next = size_overflow_reg;
        line_length_next   = line_length_reg;
        term_first_ok_next = term_first_ok_reg;
        term_count_next    = term_count_reg;
        error_code_next    = error_code_reg;

        if (s_req_type == REQ_START) begin
            phase_next         = start_phase;
            bytes_left_next    = chunked_mode_reg ? '0 : cl_len;
            size_accum_next    = '0;
            digit_seen_next    = 1'b0;
            digits_ended_next  = 1'b0;
            size_overflow_next = 1'b0;
            line_length_next   = '0;
            term_first_ok_next = 1'b0;
            term_count_next    = 1'b0;
            error_code_next    = ERR_NONE;
        end else begin
            phase_next      = eff_phase;
            bytes_left_next = eff_bytes_left;
            unique case (eff_phase)
                PH_FIXED, PH_DATA: begin
                    if (eff_bytes_left == '0) begin
                        phase_next = PH_DONE;
                    end else begin
                        bytes_left_next = eff_bytes_left - LW'(1);
                        if (eff_bytes_left == LW'(1)) begin
                            if (eff_phase == PH_FIXED) begin
                                phase_next = PH_DONE;
                            end else begin
                                phase_next         = PH_TERM;
                                term_count_next    = 1'b0;
                                term_first_ok_next = 1'b0;
                            end
                        end
                    end
                end
                PH_TERM: begin
                    if (!term_count_reg) begin
                        term_first_ok_next = (s_data_byte == CHAR_CR);
                        term_count_next    = 1'b1;
                    end else if (term_first_ok_reg && s_data_byte == CHAR_LF) begin
                        term_count_next    = 1'b0;
                        term_first_ok_next = 1'b0;
                        size_accum_next    = '0;
                        digit_seen_next    = 1'b0;
                        digits_ended_next  = 1'b0;
                        size_overflow_next = 1'b0;
                        line_length_next   = '0;
                        phase_next         = PH_SIZE;
                    end else begin
                        error_code_next = ERR_BAD_TERM;
                        phase_next      = PH_ERROR;
                    end
                end
                PH_SIZE: begin
                    if (s_data_byte == CHAR_LF) begin
                        if (!digit_seen_reg) begin
                            error_code_next = ERR_BAD_SIZE;
                            phase_next      = PH_ERROR;
                        end else if (size_overflow_reg) begin
                            error_code_next = ERR_OVERFLOW;
                            phase_next      = PH_ERROR;
                        end else if (size_accum_reg == '0) begin
                            phase_next = PH_DONE;
                        end else begin
                            bytes_left_next    = size_accum_reg;
                            size_accum_next    = '0;
                            digit_seen_next    = 1'b0;
                            digits_ended_next  = 1'b0;
                            size_overflow_next = 1'b0;
                            line_length_next   = '0;
                            phase_next         = PH_DATA;
                        end
                    end else if (line_full) begin
                        error_code_next = ERR_LONG;
                        phase_next      = PH_ERROR;
                    end else begin
                        line_length_next = line_length_reg + LINE_LEN_W'(1);
                        if (!digits_ended_reg) begin
                            if (is_hex(s_data_byte)) begin
                                if (accum_top_set) begin
                                    size_overflow_next = 1'b1;
                                end
                                size_accum_next = {size_accum_reg[LW-5:0],
                                                   hex_val(s_data_byte)};
                                digit_seen_next = 1'b1;
                            end else if (digit_seen_reg || !is_blank(s_data_byte)) begin
                                digits_ended_next = 1'b1;
                            end
                        end
                    end
                end
                PH_DONE: begin
                    phase_next = PH_DONE;
                end
                default: begin
                    phase_next = PH_ERROR;
                end
            endcase
        end
    end

    // result of the accepted item
    always_comb begin
        body_valid_next = 1'b0;
        body_byte_next  = 8'h00;
        consumed_next   = 1'b0;
        status_next     = ST_MORE;
        error_kind_next = ERR_NONE;

        if (s_req_type == REQ_START) begin
            status_next = (start_phase == PH_DONE) ? ST_BODY : ST_MORE;
        end else begin
            unique case (eff_phase)
                PH_FIXED, PH_DATA: begin
                    if (eff_bytes_left == '0) begin
                        status_next = ST_BODY;
                    end else begin
                        consumed_next   = 1'b1;
                        body_valid_next = 1'b1;
                        body_byte_next  = s_data_byte;
                        if (eff_bytes_left == LW'(1) && eff_phase == PH_FIXED) begin
                            status_next = ST_BODY;
                        end
                    end
                end
                PH_TERM: begin
                    consumed_next = 1'b1;
                    if (term_count_reg) begin
                        if (term_first_ok_reg && s_data_byte == CHAR_LF) begin
                            status_next = combine_chunks_reg ? ST_MORE : ST_CHUNK;
                        end else begin
                            status_next     = ST_ERR;
                            error_kind_next = ERR_BAD_TERM;
                        end
                    end
                end
                PH_SIZE: begin
                    consumed_next = 1'b1;
                    if (s_data_byte == CHAR_LF) begin
                        if (!digit_seen_reg) begin
                            status_next     = ST_ERR;
                            error_kind_next = ERR_BAD_SIZE;
                        end else if (size_overflow_reg) begin
                            status_next     = ST_ERR;
                            error_kind_next = ERR_OVERFLOW;
                        end else if (size_accum_reg == '0) begin
                            status_next = ST_BODY;
                        end
                    end else if (line_full) begin
                        status_next     = ST_ERR;
                        error_kind_next = ERR_LONG;
                    end
                end
                PH_DONE: begin
                    status_next = ST_BODY;
                end
                default: begin
                    status_next     = ST_ERR;
                    error_kind_next = error_code_reg;
                end
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunked_mode_reg   <= 1'b0;
            content_length_reg <= '0;
            combine_chunks_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_CHUNKED_MODE:   chunked_mode_reg   <= cfg_data[0];
                CFG_CONTENT_LENGTH: content_length_reg <= cfg_data;
                CFG_COMBINE_CHUNKS: combine_chunks_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_IDLE;
            bytes_left_reg    <= '0;
            size_accum_reg    <= '0;
            digit_seen_reg    <= 1'b0;
            digits_ended_reg  <= 1'b0;
            size_overflow_reg <= 1'b0;
            line_length_reg   <= '0;
            term_first_ok_reg <= 1'b0;
            term_count_reg    <= 1'b0;
            error_code_reg    <= ERR_NONE;
        end else if (s_accept) begin
            phase_reg         <= phase_next;
            bytes_left_reg    <= bytes_left_next;
            size_accum_reg    <= size_accum_next;
            digit_seen_reg    <= digit_seen_next;
            digits_ended_reg  <= digits_ended_next;
            size_overflow_reg <= size_overflow_next;
            line_length_reg   <= line_length_next;
            term_first_ok_reg <= term_first_ok_next;
            term_count_reg    <= term_count_next;
            error_code_reg    <= error_code_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            body_valid_reg <= body_valid_next;
            body_byte_reg  <= body_byte_next;
            consumed_reg   <= consumed_next;
            status_reg     <= status_next;
            error_kind_reg <= error_kind_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_body_valid = body_valid_reg;
    assign m_body_byte  = body_byte_reg;
    assign m_consumed   = consumed_reg;
    assign m_status     = status_reg;
    assign m_error_kind = error_kind_reg;

endmodule
